// ----- rtl/swt_pkg.sv -----
// ============================================================================
// swt_pkg: shared types and constants for the sender window tracker
// Window geometry, field widths, status codes, the controller state type and
// the command/status bundles between the controller and the datapath.
// ============================================================================
package swt_pkg;

    localparam int WINDOW      = 8;
    localparam int SEQ_SPACE   = 16384;
    localparam int CONNECTIONS = 8;
    localparam int HDR_BYTES   = 4;

    // Window and sequence space are powers of two, so slot and wrap are bit slices.
    localparam int SEQ_W    = $clog2(SEQ_SPACE);
    localparam int SLOT_W   = $clog2(WINDOW);
    localparam int CONN_W   = 3;
    localparam int LEN_W    = 11;
    localparam int PAD_W    = 2;
    localparam int FLIGHT_W = 4;

    localparam logic MODE_SEND = 1'b0;
    localparam logic MODE_RECV = 1'b1;

    typedef enum logic [2:0] {
        ST_SENT  = 3'd0,
        ST_FULL  = 3'd1,
        ST_ACK   = 3'd2,
        ST_DUP   = 3'd3,
        ST_DATA  = 3'd4
    } status_t;

    typedef struct packed {
        logic              mode;
        logic [CONN_W-1:0] conn;
        logic [SEQ_W-1:0]  rx_seq;
        logic [PAD_W-1:0]  rx_pad;
        logic [LEN_W-1:0]  pkt_len;
    } swt_in_t;

    typedef struct packed {
        status_t             status;
        logic [SEQ_W-1:0]    seq_out;
        logic [PAD_W-1:0]    pad_out;
        logic [LEN_W-1:0]    deliver_len;
        logic [FLIGHT_W-1:0] in_flight;
    } swt_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_EXEC,
        S_ADVANCE,
        S_COMMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic load;
        logic exec;
        logic advance;
        logic commit;
    } swt_cmd_t;

    typedef struct packed {
        logic adv_more;
        logic out_free;
    } swt_sts_t;

endpackage

// ----- rtl/swt_ctrl.sv -----
// ============================================================================
// swt_ctrl: sequencing controller of the sender window tracker
// Steps one item through load, evaluate, base advance and commit, and
// issues the datapath commands for each step.
// ============================================================================
module swt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  swt_pkg::swt_sts_t sts,
    output swt_pkg::swt_cmd_t cmd
);

    swt_pkg::state_t state_reg;
    swt_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= swt_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            swt_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = swt_pkg::S_LOAD;
                end
            end
            swt_pkg::S_LOAD:  state_next = swt_pkg::S_EXEC;
            swt_pkg::S_EXEC:  state_next = swt_pkg::S_ADVANCE;
            swt_pkg::S_ADVANCE: begin
                if (!sts.adv_more) begin
                    state_next = swt_pkg::S_COMMIT;
                end
            end
            swt_pkg::S_COMMIT: begin
                if (sts.out_free) begin
                    state_next = swt_pkg::S_IDLE;
                end
            end
            default: state_next = swt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            swt_pkg::S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            swt_pkg::S_LOAD:    cmd.load    = 1'b1;
            swt_pkg::S_EXEC:    cmd.exec    = 1'b1;
            swt_pkg::S_ADVANCE: cmd.advance = sts.adv_more;
            swt_pkg::S_COMMIT:  cmd.commit  = sts.out_free;
            default: begin
                cmd     = '0;
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/swt_datapath.sv -----
// ============================================================================
// swt_datapath: per-connection window state and working registers
// Holds base, next, outstanding count and acked flags of every connection,
// evaluates one item on a working copy and writes it back on commit.
// ============================================================================
module swt_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  swt_pkg::swt_in_t  s_data,
    output swt_pkg::swt_out_t m_data,
    output logic              m_valid,
    input  logic              m_ready,
    input  swt_pkg::swt_cmd_t cmd,
    output swt_pkg::swt_sts_t sts
);

    // Per-connection state; each entry is only ever read at the captured index.
    logic [swt_pkg::SEQ_W-1:0]    base_reg  [swt_pkg::CONNECTIONS];
    logic [swt_pkg::SEQ_W-1:0]    next_reg  [swt_pkg::CONNECTIONS];
    logic [swt_pkg::FLIGHT_W-1:0] cnt_reg   [swt_pkg::CONNECTIONS];
    logic [swt_pkg::WINDOW-1:0]   flags_reg [swt_pkg::CONNECTIONS];

    swt_pkg::swt_in_t             in_reg, in_next;
    logic [swt_pkg::SEQ_W-1:0]    base_w_reg, base_w_next;
    logic [swt_pkg::SEQ_W-1:0]    next_w_reg, next_w_next;
    logic [swt_pkg::FLIGHT_W-1:0] cnt_w_reg, cnt_w_next;
    logic [swt_pkg::WINDOW-1:0]   row_w_reg, row_w_next;
    logic                         adv_en_reg, adv_en_next;
    swt_pkg::status_t             res_status_reg, res_status_next;
    logic [swt_pkg::SEQ_W-1:0]    res_seq_reg, res_seq_next;
    logic [swt_pkg::PAD_W-1:0]    res_pad_reg, res_pad_next;
    logic [swt_pkg::LEN_W-1:0]    res_dlen_reg, res_dlen_next;
    swt_pkg::swt_out_t            m_data_reg, m_data_next;
    logic                         m_valid_reg, m_valid_next;

    logic                         conn_ok;
    logic [swt_pkg::CONN_W-1:0]   cidx;
    logic [swt_pkg::SEQ_W-1:0]    seq_span;
    logic                         win_full;
    logic [swt_pkg::SLOT_W-1:0]   send_slot;
    logic [swt_pkg::SLOT_W-1:0]   ack_slot;
    logic [swt_pkg::SLOT_W-1:0]   base_slot;
    logic [swt_pkg::PAD_W-1:0]    pad_calc;
    logic [swt_pkg::LEN_W-1:0]    rx_pad_ext;

    assign conn_ok = ({1'b0, in_reg.conn} < (swt_pkg::CONN_W + 1)'(swt_pkg::CONNECTIONS));
    assign cidx    = conn_ok ? in_reg.conn : '0;

    // Modular distance; the subtraction wraps in the sequence width.
    assign seq_span = next_w_reg - base_w_reg;
    assign win_full = ({1'b0, seq_span} >= (swt_pkg::SEQ_W + 1)'(swt_pkg::WINDOW));

    assign send_slot = next_w_reg[swt_pkg::SLOT_W-1:0];
    assign ack_slot  = in_reg.rx_seq[swt_pkg::SLOT_W-1:0];
    assign base_slot = base_w_reg[swt_pkg::SLOT_W-1:0];

    // Pad that brings header plus payload up to a 32-bit boundary.
    assign pad_calc   = swt_pkg::PAD_W'(2'd0 - swt_pkg::PAD_W'(
                            in_reg.pkt_len[swt_pkg::PAD_W-1:0]
                            + swt_pkg::PAD_W'(swt_pkg::HDR_BYTES)));
    assign rx_pad_ext = swt_pkg::LEN_W'(in_reg.rx_pad);

    assign sts.adv_more = adv_en_reg && (base_w_reg != next_w_reg) && row_w_reg[base_slot];
    assign sts.out_free = !m_valid_reg || m_ready;

    always_comb begin
        in_next         = in_reg;
        base_w_next     = base_w_reg;
        next_w_next     = next_w_reg;
        cnt_w_next      = cnt_w_reg;
        row_w_next      = row_w_reg;
        adv_en_next     = adv_en_reg;
        res_status_next = res_status_reg;
        res_seq_next    = res_seq_reg;
        res_pad_next    = res_pad_reg;
        res_dlen_next   = res_dlen_reg;

        if (cmd.capture) begin
            in_next = s_data;
        end

        if (cmd.load) begin
            base_w_next     = base_reg[cidx];
            next_w_next     = next_reg[cidx];
            cnt_w_next      = cnt_reg[cidx];
            row_w_next      = flags_reg[cidx];
            adv_en_next     = 1'b0;
            res_status_next = swt_pkg::ST_SENT;
            res_seq_next    = '0;
            res_pad_next    = '0;
            res_dlen_next   = '0;
        end

        if (cmd.exec) begin
            case (in_reg.mode)
                swt_pkg::MODE_SEND: begin
                    if (!conn_ok || win_full) begin
                        res_status_next = swt_pkg::ST_FULL;
                    end else begin
                        res_status_next       = swt_pkg::ST_SENT;
                        res_seq_next          = next_w_reg;
                        res_pad_next          = pad_calc;
                        next_w_next           = next_w_reg + 1'b1;
                        row_w_next[send_slot] = 1'b0;
                        cnt_w_next            = cnt_w_reg + 1'b1;
                    end
                end
                swt_pkg::MODE_RECV: begin
                    if (in_reg.pkt_len == '0) begin
                        if (!conn_ok || row_w_reg[ack_slot]) begin
                            res_status_next = swt_pkg::ST_DUP;
                        end else begin
                            res_status_next      = swt_pkg::ST_ACK;
                            row_w_next[ack_slot] = 1'b1;
                            adv_en_next          = 1'b1;
                        end
                    end else begin
                        res_status_next = swt_pkg::ST_DATA;
                        res_seq_next    = in_reg.rx_seq;
                        // A pad larger than the payload leaves the length as is.
                        res_dlen_next   = (in_reg.pkt_len >= rx_pad_ext)
                                          ? in_reg.pkt_len - rx_pad_ext
                                          : in_reg.pkt_len;
                    end
                end
                default: res_status_next = res_status_reg;
            endcase
        end

        if (cmd.advance) begin
            base_w_next = base_w_reg + 1'b1;
            if (cnt_w_reg != '0) begin
                cnt_w_next = cnt_w_reg - 1'b1;
            end
        end
    end

    always_comb begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.commit) begin
            m_valid_next             = 1'b1;
            m_data_next.status       = res_status_reg;
            m_data_next.seq_out      = res_seq_reg;
            m_data_next.pad_out      = res_pad_reg;
            m_data_next.deliver_len  = res_dlen_reg;
            m_data_next.in_flight    = conn_ok ? cnt_w_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg         <= in_next;
        base_w_reg     <= base_w_next;
        next_w_reg     <= next_w_next;
        cnt_w_reg      <= cnt_w_next;
        row_w_reg      <= row_w_next;
        res_status_reg <= res_status_next;
        res_seq_reg    <= res_seq_next;
        res_pad_reg    <= res_pad_next;
        res_dlen_reg   <= res_dlen_next;
        m_data_reg     <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adv_en_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            adv_en_reg  <= adv_en_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < swt_pkg::CONNECTIONS; i++) begin
                base_reg[i]  <= '0;
                next_reg[i]  <= '0;
                cnt_reg[i]   <= '0;
                flags_reg[i] <= '0;
            end
        end else if (cmd.commit && conn_ok) begin
            base_reg[cidx]  <= base_w_reg;
            next_reg[cidx]  <= next_w_reg;
            cnt_reg[cidx]   <= cnt_w_reg;
            flags_reg[cidx] <= row_w_reg;
        end
    end

    assign m_data  = m_data_reg;
    assign m_valid = m_valid_reg;

endmodule

// ----- rtl/sliding_window_send_ack_tracker.sv -----
// ============================================================================
// sliding_window_send_ack_tracker: selective-repeat sender window
// Top level joining the sequencing controller and the window datapath.
// ============================================================================
// Each beat on the s_ channel is either a send request or a received packet
// for one connection, and produces exactly one result beat on the m_ channel.
// The block works on one item at a time and accepts no new beat until the
// current one is committed: after acceptance the item is loaded, evaluated,
// the base advance is checked and, on an accepted ACK, the base walks forward
// slot by slot in the datapath, and the commit then registers the result.
// s_ready returns the cycle after the commit.
// A finished result sits in the output register while the next beat is
// accepted, and the commit of that next item waits only if the earlier
// result has still not been taken.
module sliding_window_send_ack_tracker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  swt_pkg::swt_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output swt_pkg::swt_out_t m_data
);

    swt_pkg::swt_cmd_t cmd;
    swt_pkg::swt_sts_t sts;

    swt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    swt_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_data  (m_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // A new result only appears through a commit.
    a_valid_from_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.commit))
        else $error("result valid rose without a commit");

    // A commit never overwrites a result that is still waiting.
    a_commit_output_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid || m_ready))
        else $error("commit while the output register was still held");

    // The outstanding count never exceeds the window.
    a_flight_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.in_flight <= swt_pkg::FLIGHT_W'(swt_pkg::WINDOW)))
        else $error("in_flight beyond the window size");

    // The base only walks inside the evaluation sequence.
    a_advance_on_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.advance |-> !s_ready && !cmd.commit)
        else $error("base advance outside the evaluation sequence");

endmodule
